/* src/lerb_pkg.sv */
// lerb_pkg: shared types and constants for the line echo ring buffer
// no dependencies; imported by lerb_ctrl and line_echo_ring_buffer_top
`default_nettype none

package lerb_pkg;

  // opcode values of an input word
  localparam logic OP_RX    = 1'b0;  // byte received
  localparam logic OP_READY = 1'b1;  // transmitter ready for next byte

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       stops_after;
  } out_word_t;

  // read slot status passed from control to the output stage
  typedef struct packed {
    logic valid;
    logic stop;
  } rd_slot_t;

  function automatic logic is_line_end(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [7:0] line_end_partner(input logic [7:0] c);
    return (c == CH_LF) ? CH_CR : CH_LF;
  endfunction

endpackage

`default_nettype wire

/* src/lerb_line_mem.sv */
// lerb_line_mem: line store, one write port and one registered read port
// no package dependency
`default_nettype none

module lerb_line_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/lerb_ctrl.sv */
// lerb_ctrl: pointers, sending flags, second write of a line end, read slot
// depends on lerb_pkg; drives the ports of lerb_line_mem
`default_nettype none

module lerb_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire lerb_pkg::in_word_t  in_word,
  output logic                     in_stall,
  input  wire logic                out_free,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [7:0]               mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  wire logic [7:0]          rd_data,
  output lerb_pkg::rd_slot_t       slot
);

  import lerb_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic          sending;
  logic          stop_pending;
  logic          second_pending;
  logic [7:0]    second_byte;

  logic accept;
  logic rx_acc;
  logic rd_acc;
  logic slot_adv;
  logic pend_now;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign slot_adv = slot.valid && out_free;
  // second write of a line end owns the write port; a held slot blocks reads
  assign in_stall = second_pending || (slot.valid && !out_free);
  assign accept   = in_valid && !in_stall;
  assign rx_acc   = accept && (in_word.opcode == OP_RX);
  assign rd_acc   = accept && (in_word.opcode == OP_READY) && sending;

  // stop pending as seen after the item in the read slot resolves
  assign pend_now = slot.valid ? (!slot.stop && is_line_end(rd_data)) : stop_pending;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = in_word.rx_byte;
    if (second_pending) begin
      mem_we    = 1'b1;
      mem_wdata = second_byte;
    end else if (rx_acc) begin
      mem_we    = 1'b1;
    end
  end

  assign mem_re    = rd_acc;
  assign mem_raddr = rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr           <= '0;
      rptr           <= '0;
      sending        <= 1'b0;
      stop_pending   <= 1'b0;
      second_pending <= 1'b0;
      slot           <= '0;
    end else begin
      if (mem_we) begin
        wptr <= wrap_inc(wptr);
      end
      second_pending <= rx_acc && is_line_end(in_word.rx_byte);
      if (rx_acc && is_line_end(in_word.rx_byte)) begin
        sending <= 1'b1;
      end else if (rd_acc && pend_now) begin
        sending <= 1'b0;
      end
      if (rd_acc) begin
        rptr         <= wrap_inc(rptr);
        stop_pending <= 1'b0;
        slot.valid   <= 1'b1;
        slot.stop    <= pend_now;
      end else if (slot_adv) begin
        stop_pending <= pend_now;
        slot.valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_acc) begin
      second_byte <= line_end_partner(in_word.rx_byte);
    end
  end

endmodule

`default_nettype wire

/* src/line_echo_ring_buffer_top.sv */
// line_echo_ring_buffer_top: top level of the line echo ring buffer
// depends on lerb_pkg, lerb_ctrl and lerb_line_mem
`default_nettype none

// Line echo ring buffer. Each input word is either a received byte (opcode 0)
// or a transmitter-ready event (opcode 1). Received bytes go into a DEPTH-entry
// ring at the write pointer; a CR or LF is followed by its partner (LF or CR)
// and switches sending on. While sending, each ready event reads one byte at
// the read pointer and emits it as an output word; once a CR or LF has been
// sent, one more byte goes out with stops_after set and sending switches off.
// A ready event while not sending is taken and gives no output word. Both
// pointers wrap at DEPTH and overrun is not flagged. A CR or LF is followed
// by a stall: its partner is written through the single write port of the
// line store in the following cycle, during which in_stall is high (this also
// keeps a read away from the entry being written). The output word of a ready
// event passes through the memory read register and then the output
// register, and waits in the read slot while the output register is held.
// in_stall also rises when a read result and the output register are both
// waiting on out_stall. The store has no reset; entries are valid once
// written.

module line_echo_ring_buffer_top #(
  parameter int DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire lerb_pkg::in_word_t  in_word,
  output logic                     in_stall,
  output logic                     out_valid,
  output lerb_pkg::out_word_t      out_word,
  input  wire logic                out_stall
);

  import lerb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rd_data;
  rd_slot_t      slot;
  logic          out_free;

  // output register can take the read slot when empty or being drained
  assign out_free = !out_valid || !out_stall;

  lerb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .rd_data   (rd_data),
    .slot      (slot)
  );

  lerb_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // output register: holds a word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot.valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot.valid && out_free) begin
      out_word.tx_byte     <= rd_data;
      out_word.stops_after <= slot.stop;
    end
  end

endmodule

`default_nettype wire
